// File: design/dfd_pkg.sv
// Shared types and constants for the DLE STX / DLE ETX deframer.
// Used by the classifier, the token queue, the frame engine and the top level.
package dfd_pkg;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_DLE = 8'h10;

  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

  // Token queue between the classifier and the frame engine.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CLS_DLE   = 2'd0,
    CLS_STX   = 2'd1,
    CLS_ETX   = 2'd2,
    CLS_OTHER = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    PH_WAIT_DLE = 2'd0,
    PH_WAIT_STX = 2'd1,
    PH_DATA     = 2'd2,
    PH_DATA_DLE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_END      = 3'd1,
    KIND_ABORT    = 3'd2,
    KIND_RESTART  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    cls_t       cls;
    logic       buffer_ready;
  } token_t;

endpackage

// File: design/dfd_classify.sv
// Front end of the deframer: takes input beats and tags each byte as DLE, STX,
// ETX or other before it enters the token queue. Depends on dfd_pkg.
module dfd_classify (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  input  logic            in_buffer_ready,
  input  logic            q_full,
  output logic            push,
  output dfd_pkg::token_t push_tok
);

  dfd_pkg::cls_t cls;

  always_comb begin
    case (in_rx_byte)
      dfd_pkg::CH_DLE: cls = dfd_pkg::CLS_DLE;
      dfd_pkg::CH_STX: cls = dfd_pkg::CLS_STX;
      dfd_pkg::CH_ETX: cls = dfd_pkg::CLS_ETX;
      default:         cls = dfd_pkg::CLS_OTHER;
    endcase
  end

  assign in_ready              = !q_full;
  assign push                  = in_valid && !q_full;
  assign push_tok.rx_byte      = in_rx_byte;
  assign push_tok.cls          = cls;
  assign push_tok.buffer_ready = in_buffer_ready;

endmodule

// File: design/dfd_queue.sv
// Short token queue that decouples the classifier from the frame engine.
// Depends on dfd_pkg for the token type and the depth constants.
module dfd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dfd_pkg::token_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output dfd_pkg::token_t q_tok
);

  dfd_pkg::token_t mem [dfd_pkg::QDEPTH];

  logic [dfd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dfd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dfd_pkg::QCNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == dfd_pkg::QCNT_W'(dfd_pkg::QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_tok   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == dfd_pkg::QPTR_W'(dfd_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + dfd_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == dfd_pkg::QPTR_W'(dfd_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + dfd_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + dfd_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - dfd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// File: design/dfd_engine.sv
// Back end of the deframer: the frame state machine, the payload byte count
// and the registered result stage. Depends on dfd_pkg.
module dfd_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [15:0]     max_len,
  input  logic            q_valid,
  input  dfd_pkg::token_t q_tok,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_data_byte,
  output logic [15:0]     out_frame_length
);

  dfd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  dfd_pkg::kind_t  out_kind_r;
  logic [7:0]      out_data_byte_r;
  logic [15:0]     out_frame_length_r;

  logic            take;
  logic            store;
  logic            emit;
  dfd_pkg::kind_t  emit_kind;
  logic [7:0]      emit_data;
  logic [15:0]     emit_len;

  always_comb begin
    take      = q_valid && (!out_valid_r || out_ready);
    phase_nxt = phase_r;
    count_nxt = count_r;
    store     = 1'b0;
    emit      = 1'b0;
    emit_kind = dfd_pkg::KIND_DATA;
    emit_data = '0;
    emit_len  = '0;
    if (take) begin
      case (phase_r)
        dfd_pkg::PH_WAIT_DLE: begin
          if (q_tok.cls == dfd_pkg::CLS_DLE) begin
            phase_nxt = dfd_pkg::PH_WAIT_STX;
          end
        end
        dfd_pkg::PH_WAIT_STX: begin
          // A frame opens only when a receive buffer is on hand.
          if (q_tok.cls == dfd_pkg::CLS_STX && q_tok.buffer_ready) begin
            count_nxt = '0;
            phase_nxt = dfd_pkg::PH_DATA;
          end else begin
            phase_nxt = dfd_pkg::PH_WAIT_DLE;
          end
        end
        dfd_pkg::PH_DATA: begin
          if (q_tok.cls == dfd_pkg::CLS_DLE) begin
            phase_nxt = dfd_pkg::PH_DATA_DLE;
          end else begin
            store = 1'b1;
          end
        end
        dfd_pkg::PH_DATA_DLE: begin
          case (q_tok.cls)
            dfd_pkg::CLS_DLE: begin
              store = 1'b1;
            end
            dfd_pkg::CLS_STX: begin
              // Restart keeps the buffer already held.
              count_nxt = '0;
              phase_nxt = dfd_pkg::PH_DATA;
              emit      = 1'b1;
              emit_kind = dfd_pkg::KIND_RESTART;
            end
            dfd_pkg::CLS_ETX: begin
              phase_nxt = dfd_pkg::PH_WAIT_DLE;
              emit      = 1'b1;
              emit_kind = dfd_pkg::KIND_END;
              emit_len  = count_r;
            end
            default: begin
              phase_nxt = dfd_pkg::PH_WAIT_DLE;
              emit      = 1'b1;
              emit_kind = dfd_pkg::KIND_ABORT;
            end
          endcase
        end
        default: begin
          phase_nxt = dfd_pkg::PH_WAIT_DLE;
        end
      endcase
      if (store) begin
        emit = 1'b1;
        if (count_r < max_len) begin
          count_nxt = count_r + 16'd1;
          phase_nxt = dfd_pkg::PH_DATA;
          emit_kind = dfd_pkg::KIND_DATA;
          emit_data = q_tok.rx_byte;
        end else begin
          phase_nxt = dfd_pkg::PH_WAIT_DLE;
          emit_kind = dfd_pkg::KIND_OVERFLOW;
        end
      end
    end
    if (take) begin
      out_valid_nxt = emit;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dfd_pkg::PH_WAIT_DLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_kind_r         <= emit_kind;
      out_data_byte_r    <= emit_data;
      out_frame_length_r <= emit_len;
    end
  end

  assign pop              = take;
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_data_byte    = out_data_byte_r;
  assign out_frame_length = out_frame_length_r;

  // A byte seen while hunting for the opening DLE never yields a result.
  a_wait_dle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == dfd_pkg::PH_WAIT_DLE |=> !out_valid_r)
    else $error("result produced while waiting for DLE");

  // A held result blocks the queue.
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !take)
    else $error("token consumed while the result stage is stalled");

  // A restart leaves an empty frame in the data phase.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == dfd_pkg::PH_DATA_DLE && q_tok.cls == dfd_pkg::CLS_STX
    |=> count_r == '0 && phase_r == dfd_pkg::PH_DATA)
    else $error("restart did not clear the frame");

  // Only frame ends carry a length, only data beats carry a byte.
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r == dfd_pkg::KIND_END || out_frame_length_r == '0)
                 && (out_kind_r == dfd_pkg::KIND_DATA || out_data_byte_r == '0))
    else $error("unused result field not zero");

endmodule

// File: design/dle_frame_deframer_unit.sv
// Top level of the DLE STX / DLE ETX byte-stuffed deframer.
// Instantiates dfd_classify, dfd_queue and dfd_engine; depends on dfd_pkg.
//
//   Channel  Direction  Beat contents
//   in_      sink       rx_byte, buffer_ready
//   out_     source     kind, data_byte, frame_length
//   cfg_     sink       max_frame_length
//
// One byte is accepted per cycle when the output is taken every cycle.
// A result passes through the two-entry token queue and then the frame engine's
// result register before it appears.
// Reset is synchronous and active low; the maximum length returns to 65535.
// An output stall holds the result register and fills the queue; in_ready
// falls once both queue entries are occupied.
module dle_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_buffer_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_frame_length
);

  logic [15:0]     max_len_r;
  logic            q_full;
  logic            push;
  dfd_pkg::token_t push_tok;
  logic            pop;
  logic            q_valid;
  dfd_pkg::token_t q_tok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= dfd_pkg::MAX_LEN_RESET;
    end else if (cfg_valid) begin
      max_len_r <= cfg_max_frame_length;
    end
  end

  dfd_classify u_classify (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .in_buffer_ready (in_buffer_ready),
    .q_full          (q_full),
    .push            (push),
    .push_tok        (push_tok)
  );

  dfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  dfd_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .max_len          (max_len_r),
    .q_valid          (q_valid),
    .q_tok            (q_tok),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_length (out_frame_length)
  );

endmodule

// File: test/dle_deframe_checker.sv
`timescale 1ns / 100ps
// Checker for the DLE STX / DLE ETX deframer: watches the byte, result and register
// channels, predicts every result and compares it with what the block delivers.
// Depends on dfd_pkg for the control characters, phases and result kinds.

module dle_deframe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_buffer_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_data_byte,
  input  logic [15:0] out_frame_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_max_frame_length,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          frames_closed,
  output int          overflow_aborts
);

  typedef struct packed {
    dfd_pkg::kind_t kind;
    logic [7:0]     data;
    logic [15:0]    len;
  } deframe_event_t;

  deframe_event_t expected_events[$];

  dfd_pkg::phase_t rx_phase = dfd_pkg::PH_WAIT_DLE;
  logic [15:0]     payload_count = '0;
  logic [15:0]     max_length = dfd_pkg::MAX_LEN_RESET;
  int              mismatches = 0;
  int              n_results = 0;
  int              n_closed = 0;
  int              n_overflow = 0;

  task automatic report_failure(input string what);
    mismatches++;
    if (mismatches <= 10) $display("Mismatch %0d at %0t: %s", mismatches, $realtime, what);
  endtask

  // A payload byte is kept only while the frame is below the length limit.
  task automatic store_or_overflow(input logic [7:0] b, output deframe_event_t ev);
    ev.data = 8'h00;
    ev.len  = 16'h0000;
    if (payload_count < max_length) begin
      payload_count = payload_count + 16'd1;
      rx_phase = dfd_pkg::PH_DATA;
      ev.kind = dfd_pkg::KIND_DATA;
      ev.data = b;
    end else begin
      rx_phase = dfd_pkg::PH_WAIT_DLE;
      ev.kind = dfd_pkg::KIND_OVERFLOW;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic buf_ok);
    deframe_event_t ev;
    logic           has_ev;
    has_ev  = 1'b0;
    ev.kind = dfd_pkg::KIND_DATA;
    ev.data = 8'h00;
    ev.len  = 16'h0000;
    case (rx_phase)
      dfd_pkg::PH_WAIT_DLE: begin
        if (b == dfd_pkg::CH_DLE) rx_phase = dfd_pkg::PH_WAIT_STX;
      end
      dfd_pkg::PH_WAIT_STX: begin
        if (b == dfd_pkg::CH_STX && buf_ok) begin
          payload_count = '0;
          rx_phase = dfd_pkg::PH_DATA;
        end else begin
          rx_phase = dfd_pkg::PH_WAIT_DLE;
        end
      end
      dfd_pkg::PH_DATA: begin
        if (b == dfd_pkg::CH_DLE) begin
          rx_phase = dfd_pkg::PH_DATA_DLE;
        end else begin
          store_or_overflow(b, ev);
          has_ev = 1'b1;
        end
      end
      default: begin
        has_ev = 1'b1;
        if (b == dfd_pkg::CH_DLE) begin
          store_or_overflow(b, ev);
        end else if (b == dfd_pkg::CH_STX) begin
          // Restart keeps the buffer already held, so buffer_ready is not looked at.
          payload_count = '0;
          rx_phase = dfd_pkg::PH_DATA;
          ev.kind = dfd_pkg::KIND_RESTART;
        end else begin
          rx_phase = dfd_pkg::PH_WAIT_DLE;
          if (b == dfd_pkg::CH_ETX) begin
            ev.kind = dfd_pkg::KIND_END;
            ev.len  = payload_count;
          end else begin
            ev.kind = dfd_pkg::KIND_ABORT;
          end
        end
      end
    endcase
    if (has_ev) expected_events.push_back(ev);
  endtask

  always @(posedge clk) begin : watch
    deframe_event_t want;
    if (!rst_n) begin
      rx_phase = dfd_pkg::PH_WAIT_DLE;
      payload_count = '0;
      max_length = dfd_pkg::MAX_LEN_RESET;
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) max_length = cfg_max_frame_length;
      // Results leave later than their byte is accepted, so compare before predicting.
      if (out_valid && out_ready) begin
        n_results++;
        if (out_kind == dfd_pkg::KIND_END) n_closed++;
        if (out_kind == dfd_pkg::KIND_OVERFLOW) n_overflow++;
        if (expected_events.size() == 0) begin
          report_failure($sformatf("unexpected result kind %0d data %02h length %0d",
                                   out_kind, out_data_byte, out_frame_length));
        end else begin
          want = expected_events.pop_front();
          if (out_kind !== want.kind || out_data_byte !== want.data ||
              out_frame_length !== want.len)
            report_failure($sformatf(
              "expected kind %0d data %02h length %0d, got kind %0d data %02h length %0d",
              want.kind, want.data, want.len, out_kind, out_data_byte, out_frame_length));
        end
      end
      if (in_valid && in_ready) deframe_byte(in_rx_byte, in_buffer_ready);
    end
    fail_count      <= mismatches;
    pending         <= expected_events.size();
    results_seen    <= n_results;
    frames_closed   <= n_closed;
    overflow_aborts <= n_overflow;
  end

endmodule

// File: test/dle_frame_deframer_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for dle_frame_deframer_unit: drives bytes, register writes and result
// back-pressure, and gives the verdict. Depends on dfd_pkg and dle_deframe_checker.

module dle_frame_deframer_unit_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_buffer_ready = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_frame_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_max_frame_length = 16'hFFFF;

  int chk_failures, chk_pending, chk_results, chk_closed, chk_overflows;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int items_counted = 0;

  dle_frame_deframer_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .in_buffer_ready      (in_buffer_ready),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_data_byte        (out_data_byte),
    .out_frame_length     (out_frame_length),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_frame_length (cfg_max_frame_length)
  );

  dle_deframe_checker chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .in_buffer_ready      (in_buffer_ready),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_data_byte        (out_data_byte),
    .out_frame_length     (out_frame_length),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_frame_length (cfg_max_frame_length),
    .fail_count           (chk_failures),
    .pending              (chk_pending),
    .results_seen         (chk_results),
    .frames_closed        (chk_closed),
    .overflow_aborts      (chk_overflows)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // A long hold-off is counted here so the sender keeps offering while results back up.
  always @(posedge clk) begin
    if (hold_requests != holds_done) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped at the cycle limit with %0d results outstanding", chk_pending);
    $display("dle_frame_deframer_unit verification failed");
    $finish;
  end

  // Offers one byte and returns at the edge that accepts it, leaving valid high.
  task automatic push_byte(input logic [7:0] b, input logic buf_ok, input logic counted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_rx_byte      <= b;
    in_buffer_ready <= buf_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (counted) items_counted++;
  endtask

  // A data DLE goes out doubled.
  task automatic push_payload(input logic [7:0] b);
    if (b == dfd_pkg::CH_DLE) push_byte(dfd_pkg::CH_DLE, 1'($urandom_range(0, 1)), 1'b1);
    push_byte(b, 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    // Bytes that cause no result may still be in the queue or the engine.
    repeat (6) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    cfg_valid            <= 1'b1;
    cfg_max_frame_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames with random content; the rest is noise and broken endings.
  task automatic send_random_stretch();
    int          n;
    int          pick;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
    end else begin
      push_byte(dfd_pkg::CH_DLE, 1'($urandom_range(0, 1)), 1'b1);
      push_byte(dfd_pkg::CH_STX, $urandom_range(0, 9) != 0, 1'b1);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 10);
      repeat (n) begin
        if ($urandom_range(0, 29) == 0) begin
          push_byte(dfd_pkg::CH_DLE, 1'($urandom_range(0, 1)), 1'b1);
          push_byte(dfd_pkg::CH_STX, 1'($urandom_range(0, 1)), 1'b1);
        end
        push_payload(8'($urandom));
      end
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        push_byte(dfd_pkg::CH_DLE, 1'($urandom_range(0, 1)), 1'b1);
        push_byte(dfd_pkg::CH_ETX, 1'($urandom_range(0, 1)), 1'b1);
      end else if (pick == 8) begin
        do b = 8'($urandom);
        while (b == dfd_pkg::CH_DLE || b == dfd_pkg::CH_STX || b == dfd_pkg::CH_ETX);
        push_byte(dfd_pkg::CH_DLE, 1'($urandom_range(0, 1)), 1'b1);
        push_byte(b, 1'($urandom_range(0, 1)), 1'b1);
      end
    end
  endtask

  task automatic run_segment(input int send_pct, input int recv_pct,
                             input logic [15:0] max_len, input int item_goal,
                             input logic with_hold);
    int goal_end;
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    write_max_length(max_len);
    goal_end = items_counted + item_goal;
    while (items_counted < goal_end) begin
      if (with_hold && hold_requests == 0 && items_counted > goal_end - item_goal / 2)
        hold_requests <= hold_requests + 1;
      send_random_stretch();
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limit: a clean frame with extreme bytes and a stuffed DLE.
    push_byte(dfd_pkg::CH_DLE, 1'b0, 1'b1);
    push_byte(dfd_pkg::CH_STX, 1'b1, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_payload(dfd_pkg::CH_DLE);
    push_byte(dfd_pkg::CH_DLE, 1'b1, 1'b1);
    push_byte(dfd_pkg::CH_ETX, 1'b0, 1'b1);
    // Stray byte while hunting, STX with no buffer, and DLE where STX belongs.
    push_byte(8'h55, 1'b1, 1'b0);
    push_byte(dfd_pkg::CH_DLE, 1'b1, 1'b1);
    push_byte(dfd_pkg::CH_STX, 1'b0, 1'b1);
    push_byte(dfd_pkg::CH_DLE, 1'b1, 1'b1);
    push_byte(dfd_pkg::CH_DLE, 1'b1, 1'b1);
    // Restart inside a frame, then an abort on an unknown control byte.
    push_byte(dfd_pkg::CH_DLE, 1'b1, 1'b1);
    push_byte(dfd_pkg::CH_STX, 1'b1, 1'b1);
    push_byte(8'hA5, 1'b0, 1'b1);
    push_byte(dfd_pkg::CH_DLE, 1'b0, 1'b1);
    push_byte(dfd_pkg::CH_STX, 1'b0, 1'b1);
    push_byte(8'h5A, 1'b1, 1'b1);
    push_byte(dfd_pkg::CH_DLE, 1'b1, 1'b1);
    push_byte(8'h7E, 1'b1, 1'b1);

    // Overflow on a plain byte after two stored, one of them a stuffed DLE.
    wait_idle();
    write_max_length(16'd2);
    push_byte(dfd_pkg::CH_DLE, 1'b1, 1'b1);
    push_byte(dfd_pkg::CH_STX, 1'b1, 1'b1);
    push_byte(8'h01, 1'b0, 1'b1);
    push_payload(dfd_pkg::CH_DLE);
    push_byte(8'h33, 1'b1, 1'b1);

    // A zero limit turns every payload byte into an overflow abort.
    wait_idle();
    write_max_length(16'd0);
    push_byte(dfd_pkg::CH_DLE, 1'b1, 1'b1);
    push_byte(dfd_pkg::CH_STX, 1'b1, 1'b1);
    push_byte(8'h44, 1'b1, 1'b1);

    run_segment(32, 62, 16'($urandom_range(3, 12)), 400, 1'b0);
    run_segment(62, 32, 16'd1, 200, 1'b0);
    run_segment(62, 32, 16'hFFFF, 250, 1'b1);
    run_segment(0, 0, 16'($urandom_range(8, 20)), 400, 1'b0);

    wait_idle();
    $display("Sent %0d bytes; checked %0d results, %0d closed frames, %0d overflow aborts.",
             bytes_sent, chk_results, chk_closed, chk_overflows);
    $display("Length limits 0, 1, 2, small random and 65535, with a long output hold-off.");
    if (chk_failures == 0 && chk_pending == 0) begin
      $display("dle_frame_deframer_unit verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", chk_failures, chk_pending);
      $display("dle_frame_deframer_unit verification failed");
    end
    $finish;
  end

endmodule
